// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is high
`define DTTD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked property that also holds through reset
`define DTTD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- hw/rtl/dttd_pkg.sv -----
package dttd_pkg;

   // saturation bound of every decimal exponent count
   localparam int EXPONENT_LIMIT = 2047;
   localparam int EXP_W = $clog2(EXPONENT_LIMIT + 1) + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_E_LO  = 8'h65;
   localparam logic [7:0] CH_E_UP  = 8'h45;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // one queued operation: a mantissa digit, or the end of a string with its net exponent
   typedef struct packed {
      logic                    is_end;
      logic signed [EXP_W-1:0] arg;
   } dttd_op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dttd_q_status_type;

   typedef enum logic [2:0] {
      PH_INT,
      PH_FRAC,
      PH_EXP_START,
      PH_EXP_DIGITS,
      PH_STOPPED
   } dttd_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_PREP,
      ST_NORM,
      ST_MUL,
      ST_ADD,
      ST_RND,
      ST_OUT
   } dttd_state_type;

endpackage

// ----- hw/rtl/decimal_text_to_double.sv -----
// decimal text to double: one text byte per word on req_, one IEEE 754 double
// per zero-terminated string on rsp_. the grammar is digits [. digits]
// [e|E [+|-] digits]; the first byte that does not fit stops parsing and the
// rest up to the zero byte is dropped, so a leading sign gives +0.0. every
// mantissa digit is folded in as value*10.0 + digit with double rounding to
// nearest even, and on the zero byte the value is multiplied |n| times by
// 10.0 or 0.1, n being the net decimal exponent saturated at +/-2047.
// the front end takes a byte every cycle while its 4-entry op queue has room;
// bytes that are not mantissa digits or the terminator cost nothing further.
// the back end has one shared double multiplier built from four 27x27
// partial products: a mantissa digit goes through multiply, round, add and
// round, and each scaling step at the end through prepare, multiply and
// round, with normalize steps for the leading zeros when the value has
// gone subnormal. scaling stops early once the value is zero or infinity.
// the result then waits in an output register, so the next string is
// parsed while it is not yet taken.
module decimal_text_to_double (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [63:0] value_bits
);
   import dttd_pkg::*;

   // ops flow front -> queue -> back
   logic              push_valid;
   dttd_op_type       push_op;
   dttd_op_type       head_op;
   dttd_q_status_type q_status;
   logic              pop;

   // byte classifier and exponent counters
   dttd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_op    (push_op),
      .q_status   (q_status)
   );

   // short op queue decouples parsing from the arithmetic
   dttd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .pop        (pop),
      .head_op    (head_op),
      .q_status   (q_status)
   );

   // double multiply/add sequencer and output register
   dttd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_op    (head_op),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hw/rtl/dttd_front.sv -----
module dttd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,
   output logic                        push_valid,
   output dttd_pkg::dttd_op_type       push_op,
   input  dttd_pkg::dttd_q_status_type q_status
);
   import dttd_pkg::*;

   localparam logic signed [EXP_W:0]   POS_LIM_W = (EXP_W + 1)'(EXPONENT_LIMIT);
   localparam logic signed [EXP_W:0]   NEG_LIM_W = -((EXP_W + 1)'(EXPONENT_LIMIT));
   localparam logic signed [EXP_W-1:0] NEG_LIMIT = -(EXP_W'(EXPONENT_LIMIT));

   dttd_phase_type          phase_ff, phase_in;
   logic signed [EXP_W-1:0] dexp_ff, dexp_in;
   logic [EXP_W-2:0]        edig_ff, edig_in;
   logic                    eneg_ff, eneg_in;

   logic                    accept;
   logic [7:0]              dsub;
   logic [3:0]              dval;
   logic                    is_digit;
   logic                    is_mark;
   logic [EXP_W+2:0]        ev;
   logic [EXP_W-2:0]        edig_sat;
   logic signed [EXP_W:0]   net_wide;
   logic signed [EXP_W:0]   net_sat;

   always_comb begin
      accept     = req_tvalid && !q_status.full;
      req_tready = !q_status.full;
      dsub       = req_tdata - CH_ZERO;
      dval       = dsub[3:0];
      is_digit   = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
      is_mark    = (req_tdata == CH_E_LO) || (req_tdata == CH_E_UP);

      ev = ((EXP_W + 3)'(edig_ff) << 3) + ((EXP_W + 3)'(edig_ff) << 1) + (EXP_W + 3)'(dval);
      edig_sat = (ev > (EXP_W + 3)'(EXPONENT_LIMIT)) ? (EXP_W - 1)'(EXPONENT_LIMIT)
                                                    : ev[EXP_W-2:0];

      if (eneg_ff) begin
         net_wide = $signed({dexp_ff[EXP_W-1], dexp_ff}) - $signed({2'b00, edig_ff});
      end else begin
         net_wide = $signed({dexp_ff[EXP_W-1], dexp_ff}) + $signed({2'b00, edig_ff});
      end
      if (net_wide > POS_LIM_W) begin
         net_sat = POS_LIM_W;
      end else if (net_wide < NEG_LIM_W) begin
         net_sat = NEG_LIM_W;
      end else begin
         net_sat = net_wide;
      end

      phase_in       = phase_ff;
      dexp_in        = dexp_ff;
      edig_in        = edig_ff;
      eneg_in        = eneg_ff;
      push_valid     = 1'b0;
      push_op.is_end = 1'b0;
      push_op.arg    = EXP_W'(dval);

      if (accept) begin
         if (req_tdata == CH_NUL) begin
            // end of string: hand over the net exponent and start over
            push_valid     = 1'b1;
            push_op.is_end = 1'b1;
            push_op.arg    = net_sat[EXP_W-1:0];
            phase_in       = PH_INT;
            dexp_in        = '0;
            edig_in        = '0;
            eneg_in        = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_INT: begin
                  if (is_digit) begin
                     push_valid = 1'b1;
                  end else if (req_tdata == CH_DOT) begin
                     phase_in = PH_FRAC;
                  end else if (is_mark) begin
                     phase_in = PH_EXP_START;
                  end else begin
                     phase_in = PH_STOPPED;
                  end
               end
               PH_FRAC: begin
                  if (is_digit) begin
                     push_valid = 1'b1;
                     if (dexp_ff > NEG_LIMIT) begin
                        dexp_in = dexp_ff - EXP_W'(1);
                     end
                  end else if (is_mark) begin
                     phase_in = PH_EXP_START;
                  end else begin
                     phase_in = PH_STOPPED;
                  end
               end
               PH_EXP_START: begin
                  if (req_tdata == CH_PLUS) begin
                     phase_in = PH_EXP_DIGITS;
                  end else if (req_tdata == CH_MINUS) begin
                     eneg_in  = 1'b1;
                     phase_in = PH_EXP_DIGITS;
                  end else if (is_digit) begin
                     edig_in  = edig_sat;
                     phase_in = PH_EXP_DIGITS;
                  end else begin
                     phase_in = PH_STOPPED;
                  end
               end
               PH_EXP_DIGITS: begin
                  if (is_digit) begin
                     edig_in = edig_sat;
                  end else begin
                     phase_in = PH_STOPPED;
                  end
               end
               default: begin
                  phase_in = PH_STOPPED;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_INT;
         dexp_ff  <= '0;
         edig_ff  <= '0;
         eneg_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         dexp_ff  <= dexp_in;
         edig_ff  <= edig_in;
         eneg_ff  <= eneg_in;
      end
   end

endmodule

// ----- hw/rtl/dttd_queue.sv -----
module dttd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  dttd_pkg::dttd_op_type       push_op,
   input  logic                        pop,
   output dttd_pkg::dttd_op_type       head_op,
   output dttd_pkg::dttd_q_status_type q_status
);
   import dttd_pkg::*;

   dttd_op_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      q_status.full  = (cnt_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
      q_status.empty = (cnt_ff == '0);
      head_op        = mem_ff[rd_ptr_ff];
      do_push        = push_valid && !q_status.full;
      do_pop         = pop && !q_status.empty;
      wr_ptr_in      = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in      = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in         = cnt_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/dttd_back.sv -----
module dttd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  dttd_pkg::dttd_op_type       head_op,
   input  dttd_pkg::dttd_q_status_type q_status,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [63:0]                 rsp_tdata
);
   import dttd_pkg::*;

   localparam logic [52:0]        M_TEN   = 53'h14000000000000;
   localparam logic signed [12:0] E_TEN   = 13'sd3;
   localparam logic [52:0]        M_TENTH = 53'h1999999999999A;
   localparam logic signed [12:0] E_TENTH = -13'sd4;
   localparam logic [63:0]        D_INF   = 64'h7FF0000000000000;

   // round a nonnegative exact value w * 2^(x-105) to a double, nearest even
   function automatic logic [63:0] round_pack(input logic [109:0] w,
                                              input logic signed [12:0] x);
      logic [2:0]        o;
      logic signed [12:0] en;
      logic signed [12:0] be;
      logic signed [12:0] extra;
      logic signed [12:0] shw;
      logic [6:0]        sh;
      logic [111:0]      wx;
      logic [111:0]      shd;
      logic [111:0]      mask;
      logic [52:0]       q;
      logic              g;
      logic              s;
      logic              up;
      logic [53:0]       qr;
      logic [63:0]       res;
      o = 3'd0;
      for (int i = 0; i < 6; i++) begin
         if (w[104 + i]) begin
            o = 3'(i);
         end
      end
      en = x + 13'($unsigned(o)) - 13'sd1;
      if (en >= -13'sd1022) begin
         sh = 7'(o) + 7'd52;
      end else begin
         // below the normal range: shift further into the subnormal grid
         extra = -13'sd1022 - en;
         shw   = 13'($unsigned(o)) + 13'sd52 + extra;
         sh    = (shw > 13'sd111) ? 7'd111 : shw[6:0];
      end
      wx   = {w, 2'b00};
      shd  = wx >> sh;
      mask = ~({112{1'b1}} << sh);
      q    = shd[54:2];
      g    = shd[1];
      s    = shd[0] | (|(wx & mask));
      up   = g & (s | q[0]);
      qr   = {1'b0, q} + 54'(up);
      if (w == '0) begin
         res = 64'h0;
      end else if (en >= -13'sd1022) begin
         be = en + 13'sd1023 + 13'($unsigned(qr[53]));
         if (be >= 13'sd2047) begin
            res = D_INF;
         end else begin
            res = {1'b0, be[10:0], qr[53] ? qr[52:1] : qr[51:0]};
         end
      end else begin
         res = {11'b0, qr[52:0]};
      end
      return res;
   endfunction

   dttd_state_type     state_ff, state_in;
   logic [63:0]        acc_ff, acc_in;
   logic [3:0]         digit_ff, digit_in;
   logic [EXP_W-2:0]   count_ff, count_in;
   logic               down_ff, down_in;
   logic               mode_digit_ff, mode_digit_in;
   logic               add_phase_ff, add_phase_in;
   logic [52:0]        ma_ff, ma_in;
   logic signed [12:0] ea_ff, ea_in;
   logic [105:0]       prod_ff, prod_in;
   logic [53:0]        pp_ff, pp_in;
   logic [1:0]         ppsh_ff, ppsh_in;
   logic [2:0]         step_ff, step_in;
   logic [109:0]       rw_ff, rw_in;
   logic signed [12:0] rx_ff, rx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   logic [10:0]        ef;
   logic               a_inf;
   logic               a_zero;
   logic [52:0]        mb;
   logic signed [12:0] eb;
   logic [26:0]        al, ah, bl, bh;
   logic [105:0]       pp_shifted;
   logic [105:0]       prod_sum;
   logic signed [12:0] ea_add;
   logic [52:0]        ma_add;
   logic [12:0]        add_sh;
   logic signed [EXP_W-1:0] arg_neg;

   always_comb begin
      ef     = acc_ff[62:52];
      a_inf  = (ef == 11'h7FF);
      a_zero = (acc_ff[62:0] == 63'h0);

      if (mode_digit_ff || !down_ff) begin
         mb = M_TEN;
         eb = E_TEN;
      end else begin
         mb = M_TENTH;
         eb = E_TENTH;
      end
      al = ma_ff[26:0];
      ah = {1'b0, ma_ff[52:27]};
      bl = mb[26:0];
      bh = {1'b0, mb[52:27]};

      case (ppsh_ff)
         2'd0:    pp_shifted = 106'(pp_ff);
         2'd1:    pp_shifted = 106'(pp_ff) << 27;
         default: pp_shifted = 106'(pp_ff) << 54;
      endcase
      prod_sum = prod_ff + pp_shifted;

      ea_add = a_zero ? 13'sd0 : ($signed({2'b00, ef}) - 13'sd1023);
      ma_add = a_zero ? 53'h0 : {1'b1, acc_ff[51:0]};
      add_sh = 13'sd105 - ea_add;
      arg_neg = -head_op.arg;

      state_in      = state_ff;
      acc_in        = acc_ff;
      digit_in      = digit_ff;
      count_in      = count_ff;
      down_in       = down_ff;
      mode_digit_in = mode_digit_ff;
      add_phase_in  = add_phase_ff;
      ma_in         = ma_ff;
      ea_in         = ea_ff;
      prod_in       = prod_ff;
      pp_in         = pp_ff;
      ppsh_in       = ppsh_ff;
      step_in       = step_ff;
      rw_in         = rw_ff;
      rx_in         = rx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      pop           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (head_op.is_end) begin
                  mode_digit_in = 1'b0;
                  down_in       = head_op.arg[EXP_W-1];
                  count_in      = head_op.arg[EXP_W-1] ? arg_neg[EXP_W-2:0]
                                                       : head_op.arg[EXP_W-2:0];
                  state_in      = ST_SCALE;
               end else begin
                  mode_digit_in = 1'b1;
                  digit_in      = head_op.arg[3:0];
                  add_phase_in  = 1'b0;
                  // infinity absorbs the digit, zero needs no multiply
                  if (a_inf) begin
                     state_in = ST_IDLE;
                  end else if (a_zero) begin
                     state_in = ST_ADD;
                  end else begin
                     state_in = ST_PREP;
                  end
               end
            end
         end
         ST_SCALE: begin
            if ((count_ff == '0) || a_zero || a_inf) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            ma_in   = {(ef != 11'h0), acc_ff[51:0]};
            ea_in   = (ef == 11'h0) ? -13'sd1022 : ($signed({2'b00, ef}) - 13'sd1023);
            prod_in = '0;
            step_in = 3'd0;
            state_in = (ef == 11'h0) ? ST_NORM : ST_MUL;
         end
         ST_NORM: begin
            if (ma_ff[52]) begin
               state_in = ST_MUL;
            end else begin
               ma_in = {ma_ff[51:0], 1'b0};
               ea_in = ea_ff - 13'sd1;
            end
         end
         ST_MUL: begin
            if (step_ff != 3'd0) begin
               prod_in = prod_sum;
            end
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  pp_in   = al * bl;
                  ppsh_in = 2'd0;
               end
               3'd1: begin
                  pp_in   = al * bh;
                  ppsh_in = 2'd1;
               end
               3'd2: begin
                  pp_in   = ah * bl;
                  ppsh_in = 2'd1;
               end
               3'd3: begin
                  pp_in   = ah * bh;
                  ppsh_in = 2'd2;
               end
               default: begin
                  rw_in    = {4'b0000, prod_sum};
                  rx_in    = ea_ff + eb + 13'sd1;
                  state_in = ST_RND;
               end
            endcase
         end
         ST_ADD: begin
            add_phase_in = 1'b1;
            if (ea_add <= 13'sd105) begin
               rw_in = {4'b0000, ma_add, 53'h0} + (110'(digit_ff) << add_sh[6:0]);
            end else begin
               rw_in = {4'b0000, ma_add, 53'h0};
            end
            rx_in    = ea_add;
            state_in = ST_RND;
         end
         ST_RND: begin
            acc_in = round_pack(rw_ff, rx_ff);
            if (mode_digit_ff) begin
               state_in = add_phase_ff ? ST_IDLE : ST_ADD;
            end else begin
               count_in = count_ff - (EXP_W - 1)'(1);
               state_in = ST_SCALE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               acc_in       = 64'h0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         acc_ff        <= 64'h0;
         rsp_valid_ff  <= 1'b0;
         mode_digit_ff <= 1'b0;
         add_phase_ff  <= 1'b0;
         count_ff      <= '0;
         step_ff       <= 3'd0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         rsp_valid_ff  <= rsp_valid_in;
         mode_digit_ff <= mode_digit_in;
         add_phase_ff  <= add_phase_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff    <= digit_in;
      down_ff     <= down_in;
      ma_ff       <= ma_in;
      ea_ff       <= ea_in;
      prod_ff     <= prod_in;
      pp_ff       <= pp_in;
      ppsh_ff     <= ppsh_in;
      rw_ff       <= rw_in;
      rx_ff       <= rx_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hw/rtl/dttd_checker.sv -----
`include "assert_macros.svh"

module dttd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // a stalled result word holds
   `DTTD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // parsed values are never negative
   `DTTD_ASSERT(a_rsp_nonneg, clock, reset, rsp_tvalid |-> !rsp_tdata[63])

   // overflow gives infinity, never a nan
   `DTTD_ASSERT(a_rsp_no_nan, clock, reset, rsp_tvalid && (rsp_tdata[62:52] == 11'h7FF) |-> (rsp_tdata[51:0] == 52'h0))

   // reset leaves no result pending and the input open
   `DTTD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind decimal_text_to_double dttd_checker u_dttd_checker (.*);

// ----- sim/dttd_checker.sv -----
`timescale 1ns / 100ps

// watches both channels, parses the accepted text bytes on its own and
// compares every returned double with the oldest predicted one
module dttd_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [63:0] value_bits
   output int          fail_count,
   output int          pending,
   output int          checked
);
   import dttd_pkg::*;

   dttd_phase_type phase;
   real            mant;
   int             frac_exp;
   int             exp_mag;
   logic           exp_neg;
   logic [63:0]    expected_values[$];

   function automatic logic is_digit(logic [7:0] ch);
      return ch >= CH_ZERO && ch <= CH_NINE;
   endfunction

   function automatic logic is_mark(logic [7:0] ch);
      return ch == CH_E_LO || ch == CH_E_UP;
   endfunction

   // scale by the net exponent, one multiply per step
   function automatic logic [63:0] scaled_bits(real v, int net);
      real a;
      a = v;
      if (net > EXPONENT_LIMIT) net = EXPONENT_LIMIT;
      if (net < -EXPONENT_LIMIT) net = -EXPONENT_LIMIT;
      while (net > 0) begin
         a = a * 10.0;
         net--;
      end
      while (net < 0) begin
         a = a * 0.1;
         net++;
      end
      return $realtobits(a);
   endfunction

   task automatic clear_parse();
      phase    = PH_INT;
      mant     = 0.0;
      frac_exp = 0;
      exp_mag  = 0;
      exp_neg  = 1'b0;
   endtask

   task automatic take_char(logic [7:0] ch);
      int d;
      d = int'(ch) - int'(CH_ZERO);
      if (ch == CH_NUL) begin
         expected_values.insert(expected_values.size(),
                                scaled_bits(mant, exp_neg ? frac_exp - exp_mag
                                                          : frac_exp + exp_mag));
         clear_parse();
         return;
      end
      case (phase)
         PH_INT: begin
            if (is_digit(ch)) mant = mant * 10.0 + real'(d);
            else if (ch == CH_DOT) phase = PH_FRAC;
            else if (is_mark(ch)) phase = PH_EXP_START;
            else phase = PH_STOPPED;
         end
         PH_FRAC: begin
            if (is_digit(ch)) begin
               mant = mant * 10.0 + real'(d);
               if (frac_exp > -EXPONENT_LIMIT) frac_exp--;
            end else if (is_mark(ch)) phase = PH_EXP_START;
            else phase = PH_STOPPED;
         end
         PH_EXP_START: begin
            if (ch == CH_PLUS) phase = PH_EXP_DIGITS;
            else if (ch == CH_MINUS) begin
               exp_neg = 1'b1;
               phase   = PH_EXP_DIGITS;
            end else if (is_digit(ch)) begin
               exp_mag = d;
               phase   = PH_EXP_DIGITS;
            end else phase = PH_STOPPED;
         end
         PH_EXP_DIGITS: begin
            if (is_digit(ch)) begin
               exp_mag = exp_mag * 10 + d;
               if (exp_mag > EXPONENT_LIMIT) exp_mag = EXPONENT_LIMIT;
            end else phase = PH_STOPPED;
         end
         default: phase = PH_STOPPED;
      endcase
   endtask

   initial begin
      fail_count = 0;
      checked    = 0;
      pending    = 0;
      clear_parse();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         expected_values.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               if (rsp_tdata !== expected_values[0]) begin
                  $display("%0t: value_bits mismatch, expected %h, actual %h",
                           $time, expected_values[0], rsp_tdata);
                  fail_count++;
               end
               void'(expected_values.pop_front());
               checked++;
            end
         end
         if (req_tvalid && req_tready) take_char(req_tdata);
      end
      pending = expected_values.size();
   end

endmodule

// ----- sim/tb_decimal_text_to_double.sv -----
`timescale 1ns / 100ps

module tb_decimal_text_to_double;
   import dttd_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_CHARS = 950;
   localparam int DRAIN_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] character
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [63:0] value_bits

   int fail_count;
   int pending;
   int checked;
   int cycles;
   int chars_sent;
   int strings_sent;
   bit quiet_send;           // no gaps on the sending side for this stretch
   bit quiet_recv;           // no stalls on the receiving side for this stretch

   decimal_text_to_double dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dttd_scoreboard u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on the whole run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_decimal_text_to_double: done, errors");
         $finish;
      end
   end

   // receiving side: random stall before each word, then hold ready until taken
   initial begin
      bit hit;
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = quiet_recv ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            hit = rsp_tvalid;
            @(posedge clock);
         end while (!hit);
      end
   end

   // one byte on the request side; valid stays up when no gap follows
   task automatic send_char(logic [7:0] ch);
      bit hit;
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do begin
         @(negedge clock);
         hit = req_tready;
         @(posedge clock);
      end while (!hit);
      chars_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(CH_NUL);
      strings_sent++;
   endtask

   // sample the pending count between edges, then resume on a rising edge
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending != 0);
      @(posedge clock);
   endtask

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // mostly well-formed numbers, some broken ones and some plain noise
   task automatic send_random_string();
      logic [7:0] s[$];
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      if (kind < 7 || kind == 8) begin
         n = $urandom_range(0, 4) == 0 ? $urandom_range(15, 25) : $urandom_range(0, 8);
         repeat (n) s.insert(s.size(), rand_digit());
         if ($urandom_range(0, 1)) begin
            s.insert(s.size(), CH_DOT);
            repeat ($urandom_range(0, 10)) s.insert(s.size(), rand_digit());
         end
         if ($urandom_range(0, 2) == 0) begin
            s.insert(s.size(), $urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
            case ($urandom_range(0, 2))
               0: s.insert(s.size(), CH_PLUS);
               1: s.insert(s.size(), CH_MINUS);
               default: ;
            endcase
            // long exponents are rare since each step costs a multiply
            n = $urandom_range(0, 15) == 0 ? $urandom_range(3, 4) : $urandom_range(0, 2);
            repeat (n) s.insert(s.size(), rand_digit());
         end
         // broken tail: junk after the number
         if (kind == 8) begin
            repeat ($urandom_range(1, 4)) s.insert(s.size(), 8'($urandom_range(1, 255)));
         end
      end else begin
         repeat ($urandom_range(0, 8)) s.insert(s.size(), 8'($urandom_range(1, 255)));
      end
      foreach (s[i]) send_char(s[i]);
      send_char(CH_NUL);
      strings_sent++;
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      quiet_send   = 1'b0;
      quiet_recv   = 1'b0;
      chars_sent   = 0;
      strings_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty string, digit extremes, fraction, exponent forms
      send_text("");
      send_text("0");
      send_text("9");
      send_text("123.456");
      send_text("1.5e3");
      send_text("2E-2");
      send_text("7e+2");
      // leading sign stops parsing at once
      send_text("+5");
      send_text("-5");
      // exponent mark with no digits after it
      send_text("4e");
      send_text("4E-");
      // unexpected bytes stop parsing, rest dropped
      send_text("3.x7");
      send_text("1.2.3");
      send_char(8'hFF);
      send_char(8'h80);
      send_char(CH_NUL);
      // saturated exponents, overflow to infinity, underflow through subnormals
      send_text("1e99999");
      send_text("1e-99999");
      send_text("1e-320");
      send_text("99999999999999999999");

      // hold off until the block has returned every pending result
      wait_drained();

      while (chars_sent < RANDOM_CHARS) begin
         quiet_send = $urandom_range(0, 5) == 0;
         quiet_recv = $urandom_range(0, 5) == 0;
         send_random_string();
         if ($urandom_range(0, 60) == 0) wait_drained();
      end
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
      req_tvalid <= 1'b0;

      // let the last results arrive, then watch a while for stray words
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d strings in %0d bytes, %0d doubles compared",
               strings_sent, chars_sent, checked);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_decimal_text_to_double: done, clean");
      end else begin
         $display("tb_decimal_text_to_double: done, errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/dttd_pkg.sv
hw/rtl/dttd_front.sv
hw/rtl/dttd_queue.sv
hw/rtl/dttd_back.sv
hw/rtl/decimal_text_to_double.sv
hw/rtl/dttd_checker.sv
sim/dttd_checker.sv
sim/tb_decimal_text_to_double.sv
